@@ design/lust_pkg.sv @@
// Package for the lexical unit stream tokenizer.
// Holds the character codes, the lexer mode and token kind types, and the token struct.
// No dependencies.
package lust_pkg;

	localparam int CHAR_W = 21;

	localparam logic [CHAR_W-1:0] CH_CARET   = 21'h00005E;
	localparam logic [CHAR_W-1:0] CH_DOLLAR  = 21'h000024;
	localparam logic [CHAR_W-1:0] CH_LBRACK  = 21'h00005B;
	localparam logic [CHAR_W-1:0] CH_RBRACK  = 21'h00005D;
	localparam logic [CHAR_W-1:0] CH_BSLASH  = 21'h00005C;
	localparam logic [CHAR_W-1:0] CH_LBRACE  = 21'h00007B;
	localparam logic [CHAR_W-1:0] CH_RBRACE  = 21'h00007D;
	localparam logic [CHAR_W-1:0] CH_SLASH   = 21'h00002F;
	localparam logic [CHAR_W-1:0] CH_AT      = 21'h000040;
	localparam logic [CHAR_W-1:0] CH_LESS    = 21'h00003C;
	localparam logic [CHAR_W-1:0] CH_GREATER = 21'h00003E;

	typedef enum logic [2:0] {
		MODE_OUT     = 3'd0,
		MODE_OUT_ESC = 3'd1,
		MODE_IN      = 3'd2,
		MODE_IN_ESC  = 3'd3,
		MODE_BLK     = 3'd4,
		MODE_BLK_ESC = 3'd5,
		MODE_ERR     = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TEXT  = 2'd0,
		KIND_WORD  = 2'd1,
		KIND_END   = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [CHAR_W-1:0] ch;
	} tok_t;

	function automatic logic is_special(input logic [CHAR_W-1:0] c);
		return c inside {CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_CARET,
			CH_DOLLAR, CH_SLASH, CH_BSLASH, CH_AT, CH_LESS, CH_GREATER};
	endfunction

endpackage

@@ design/lust_if.sv @@
// Handshake interfaces for the character input and the token output channels.
// Depends on lust_pkg for the character width and the token kind type.
interface lust_char_if;
	logic                         valid;
	logic                         ready;
	logic [lust_pkg::CHAR_W-1:0]  char_code;
	logic                         end_mark;

	modport source (output valid, output char_code, output end_mark, input ready);
	modport sink (input valid, input char_code, input end_mark, output ready);
endinterface

interface lust_tok_if;
	logic                         valid;
	logic                         ready;
	lust_pkg::kind_t              kind;
	logic [lust_pkg::CHAR_W-1:0]  char_out;

	modport source (output valid, output kind, output char_out, input ready);
	modport sink (input valid, input kind, input char_out, output ready);
endinterface

@@ design/lust_lexer.sv @@
// Lexer mode register and the decode of one character into at most one token.
// Depends on lust_pkg.
module lust_lexer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [lust_pkg::CHAR_W-1:0] char_code,
	input  logic                        end_mark,
	output lust_pkg::tok_t              res
);
	import lust_pkg::*;

	mode_t mode_q;
	mode_t mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OUT;
		end else if (step) begin
			mode_q <= mode_d;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		res.valid = 1'b1;
		res.kind  = KIND_TEXT;
		res.ch    = char_code;
		if (mode_q == MODE_ERR) begin
			res.kind = KIND_ERROR;
			res.ch   = '0;
		end else if (end_mark) begin
			if (mode_q == MODE_BLK || mode_q == MODE_BLK_ESC) begin
				mode_d   = MODE_ERR;
				res.kind = KIND_ERROR;
				res.ch   = '0;
			end else begin
				mode_d    = MODE_OUT;
				res.valid = 1'b0;
			end
		end else begin
			case (mode_q)
				MODE_OUT_ESC: begin
					mode_d = MODE_OUT;
				end
				MODE_IN: begin
					if (char_code == CH_BSLASH) begin
						mode_d    = MODE_IN_ESC;
						res.valid = 1'b0;
					end else if (char_code == CH_DOLLAR) begin
						mode_d   = MODE_OUT;
						res.kind = KIND_END;
					end else if (char_code == CH_LBRACK) begin
						mode_d = MODE_BLK;
					end else begin
						res.kind = KIND_WORD;
					end
				end
				MODE_IN_ESC: begin
					mode_d   = MODE_IN;
					res.kind = KIND_WORD;
				end
				MODE_BLK: begin
					if (char_code == CH_BSLASH) begin
						mode_d = MODE_BLK_ESC;
					end else if (char_code == CH_RBRACK) begin
						mode_d = MODE_IN;
					end
				end
				MODE_BLK_ESC: begin
					if (is_special(char_code)) begin
						mode_d = MODE_BLK;
					end else begin
						mode_d   = MODE_ERR;
						res.kind = KIND_ERROR;
						res.ch   = '0;
					end
				end
				default: begin
					if (char_code == CH_CARET) begin
						mode_d    = MODE_IN;
						res.valid = 1'b0;
					end else if (char_code == CH_BSLASH) begin
						mode_d = MODE_OUT_ESC;
					end else begin
						mode_d = MODE_OUT;
					end
				end
			endcase
		end
	end

endmodule

@@ design/lexical_unit_stream_tokenizer.sv @@
// Caret-dollar lexical unit stream tokenizer, top level.
// A character's token, if it has one, passes from the input register through the lexer into the output register.
// Throughput: one character per cycle while the token output is not stalled, set by the single lexer mode register.
// An input register and an output register part the two channels.
// Reset clears both registers' valid flags and puts the lexer outside any word.
// Depends on lust_pkg, lust_if and lust_lexer.
module lexical_unit_stream_tokenizer (
	input  logic  clk,
	input  logic  arst_n,
	lust_char_if.sink   chars,
	lust_tok_if.source  tokens
);
	import lust_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              end_s1;
	logic              adv;
	logic              out_valid_q;
	kind_t             kind_q;
	logic [CHAR_W-1:0] char_q;
	tok_t              res;

	assign adv         = valid_s1 && (!out_valid_q || tokens.ready);
	assign chars.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			end_s1  <= chars.end_mark;
		end
	end

	lust_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.char_code (char_s1),
		.end_mark  (end_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.valid;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q <= res.kind;
			char_q <= res.ch;
		end
	end

	assign tokens.valid    = out_valid_q;
	assign tokens.kind     = kind_q;
	assign tokens.char_out = char_q;

endmodule
